[design/bnps_pkg.sv]
// Shared types, constants and prefix compare function for the boot name prefix scanner.
package bnps_pkg;

  localparam int unsigned NAME_BYTES   = 11;
  localparam int unsigned CNT_W        = $clog2(NAME_BYTES + 1);
  localparam int unsigned IDX_W        = $clog2(NAME_BYTES);
  localparam int unsigned PREFIX_COUNT = 11;
  localparam int unsigned PREFIX_MAX   = 5;

  typedef logic [NAME_BYTES-1:0][7:0] win_t;

  typedef enum logic [1:0] {
    ST_FOUND = 2'd0,
    ST_NONE  = 2'd1,
    ST_TRUNC = 2'd2
  } status_e;

  // Result request from the window stage to the output buffer.
  typedef struct packed {
    logic    load_name;
    logic    load_status;
    status_e status;
  } ev_t;

  localparam logic [PREFIX_COUNT-1:0][PREFIX_MAX-1:0][7:0] PREFIX_TABLE = '{
    '{8'h5F, 8'h53, 8'h45, 8'h43, 8'h53},
    '{8'h5F, 8'h44, 8'h45, 8'h43, 8'h53},
    '{8'h00, 8'h53, 8'h45, 8'h4C, 8'h53},
    '{8'h5F, 8'h44, 8'h45, 8'h4C, 8'h53},
    '{8'h5F, 8'h53, 8'h50, 8'h43, 8'h53},
    '{8'h5F, 8'h53, 8'h50, 8'h4C, 8'h53},
    '{8'h5F, 8'h4D, 8'h50, 8'h4C, 8'h53},
    '{8'h5F, 8'h53, 8'h55, 8'h43, 8'h53},
    '{8'h5F, 8'h53, 8'h55, 8'h4C, 8'h53},
    '{8'h5F, 8'h58, 8'h50, 8'h41, 8'h50},
    '{8'h5F, 8'h58, 8'h50, 8'h43, 8'h50}
  };

  localparam logic [PREFIX_COUNT-1:0][2:0] PREFIX_LEN = '{
    3'd5, 3'd5, 3'd4, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5
  };

  // Row 0 is listed first, so it sits in the highest packed slot; characters are
  // listed last-first, so packed slot k already holds character k.
  function automatic logic [7:0] prefix_char(int unsigned p, int unsigned k);
    return PREFIX_TABLE[PREFIX_COUNT-1-p][k];
  endfunction

  function automatic int unsigned prefix_length(int unsigned p);
    return int'(PREFIX_LEN[PREFIX_COUNT-1-p]);
  endfunction

  // True if some prefix starts at pos and ends within the first avail bytes.
  function automatic logic prefix_at(win_t win, int unsigned pos, int unsigned avail);
    logic hit;
    logic same;
    hit = 1'b0;
    for (int unsigned p = 0; p < PREFIX_COUNT; p++) begin
      same = (pos + prefix_length(p) <= avail) && (pos + prefix_length(p) <= NAME_BYTES);
      for (int unsigned k = 0; k < PREFIX_MAX; k++) begin
        if (k < prefix_length(p)) begin
          if (pos + k >= NAME_BYTES) begin
            same = 1'b0;
          end else if (win[IDX_W'(pos + k)] != prefix_char(p, k)) begin
            same = 1'b0;
          end
        end
      end
      hit = hit | same;
    end
    return hit;
  endfunction

endpackage

[design/bnps_window.sv]
// Byte window, fill count and prefix match decision for the boot name prefix scanner.
module bnps_window
  import bnps_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] byte_i,
  input  logic       last_i,
  output logic       found_o,
  output ev_t        ev_o,
  output win_t       win_o
);

  win_t             win_q, win_d;
  logic [CNT_W-1:0] seen_q, seen_d, seen_new;
  logic             found_q, found_d;
  logic             full_q, full_new, head_hit, tail_hit;
  logic [NAME_BYTES-1:0] pos_hit;

  assign full_q   = (seen_q >= CNT_W'(NAME_BYTES));
  assign seen_new = full_q ? seen_q : seen_q + CNT_W'(1);
  assign full_new = (seen_new >= CNT_W'(NAME_BYTES));

  // Append while filling, shift once full.
  always_comb begin
    for (int unsigned j = 0; j < NAME_BYTES; j++) begin
      if (!full_q) begin
        win_d[j] = (seen_q == CNT_W'(j)) ? byte_i : win_q[j];
      end else if (j == NAME_BYTES - 1) begin
        win_d[j] = byte_i;
      end else begin
        win_d[j] = win_q[j+1];
      end
    end
  end

  assign head_hit = full_new && prefix_at(win_d, 0, NAME_BYTES);

  // Untested positions at region end; position zero is already tested when full.
  always_comb begin
    for (int unsigned pos = 0; pos < NAME_BYTES; pos++) begin
      pos_hit[pos] = prefix_at(win_d, pos, int'(seen_new)) && !(full_new && pos == 0);
    end
  end
  assign tail_hit = |pos_hit;

  always_comb begin
    ev_o = '{load_name: 1'b0, load_status: 1'b0, status: ST_FOUND};
    if (accept_i && !found_q) begin
      if (head_hit) begin
        ev_o.load_name = 1'b1;
      end else if (last_i) begin
        ev_o.load_status = 1'b1;
        ev_o.status      = tail_hit ? ST_TRUNC : ST_NONE;
      end
    end
  end

  always_comb begin
    seen_d  = seen_q;
    found_d = found_q;
    if (accept_i) begin
      if (last_i) begin
        seen_d  = '0;
        found_d = 1'b0;
      end else if (!found_q) begin
        seen_d  = seen_new;
        found_d = head_hit;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q  <= '0;
      found_q <= 1'b0;
      win_q   <= '0;
    end else begin
      seen_q  <= seen_d;
      found_q <= found_d;
      if (accept_i) begin
        if (last_i) begin
          win_q <= '0;
        end else if (!found_q) begin
          win_q <= win_d;
        end
      end
    end
  end

  assign found_o = found_q;
  assign win_o   = win_d;

endmodule

[design/bnps_emit.sv]
// Result buffer that plays out a found name or a single status result.
module bnps_emit
  import bnps_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  ev_t        ev_i,
  input  win_t       win_i,
  input  logic       take_i,
  output logic       busy_o,
  output logic       final_o,
  output logic [7:0] byte_o,
  output status_e    status_o
);

  win_t             buf_q, buf_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  status_e          status_q, status_d;

  always_comb begin
    buf_d    = buf_q;
    cnt_d    = cnt_q;
    status_d = status_q;
    if (ev_i.load_name) begin
      buf_d    = win_i;
      cnt_d    = CNT_W'(NAME_BYTES);
      status_d = ST_FOUND;
    end else if (ev_i.load_status) begin
      buf_d    = '0;
      cnt_d    = CNT_W'(1);
      status_d = ev_i.status;
    end else if (take_i) begin
      // Advance to the next byte of the name.
      for (int unsigned j = 0; j < NAME_BYTES - 1; j++) begin
        buf_d[j] = buf_q[j+1];
      end
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    buf_q    <= buf_d;
    status_q <= status_d;
  end

  assign busy_o   = (cnt_q != '0);
  assign final_o  = (cnt_q == CNT_W'(1));
  assign byte_o   = buf_q[0];
  assign status_o = status_q;

endmodule

[design/boot_name_prefix_scanner_core.sv]
// Top level of the boot name prefix scanner: stream ports, window stage and result buffer.
// Each result is registered and appears in the cycle after the byte that causes it. One
// input byte per cycle; a found name plays out as eleven results, one per cycle while the
// sink is ready. Until a name is found in the region, input stalls while the buffer holds
// a result other than the final one leaving in this cycle; after a name, bytes flow freely.
// Reset (rst_ni low, asynchronous): window cleared, fill count zero, buffer empty.
module boot_name_prefix_scanner_core
  import bnps_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] data_byte
  input  logic       s_axis_tlast_i,   // end_of_region
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [7:0] name_byte
  output logic [1:0] m_axis_tuser_o,   // [1:0] status
  output logic       m_axis_tlast_o    // last_result
);

  logic    in_acc, out_take, found, busy, final_res;
  ev_t     ev;
  win_t    win;
  status_e status;

  // Once a name is found, bytes up to the end mark give no result, so take them freely.
  // Otherwise take a byte only when the buffer is empty or sends its final result now.
  assign s_axis_tready_o = found || !busy || (final_res && m_axis_tready_i);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign out_take        = busy && m_axis_tready_i;

  bnps_window u_window (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (in_acc),
    .byte_i   (s_axis_tdata_i),
    .last_i   (s_axis_tlast_i),
    .found_o  (found),
    .ev_o     (ev),
    .win_o    (win)
  );

  bnps_emit u_emit (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ev_i     (ev),
    .win_i    (win),
    .take_i   (out_take),
    .busy_o   (busy),
    .final_o  (final_res),
    .byte_o   (m_axis_tdata_o),
    .status_o (status)
  );

  assign m_axis_tvalid_o = busy;
  assign m_axis_tuser_o  = status;
  assign m_axis_tlast_o  = final_res;

  // A status result is always a single, final transaction.
  a_status_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o != ST_FOUND) |-> m_axis_tlast_o)
    else $error("status result without last mark");

  // Status results carry a zero byte.
  a_status_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o != ST_FOUND) |-> (m_axis_tdata_o == 8'h00))
    else $error("status result with nonzero byte");

  // Never load a new result over one that is still pending.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((ev.load_name || ev.load_status) && busy) |-> (final_res && m_axis_tready_i))
    else $error("result buffer overwritten");

endmodule

[tb/tb_top.sv]
// Self-checking testbench for the boot name prefix scanner core.
module tb_top;
  import bnps_pkg::*;

  localparam int unsigned QUIET_LIMIT = 2000;  // cycles without any transaction
  localparam int unsigned RANDOM_ITEMS = 500;
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam int unsigned MAX_REGION = 40;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } region_byte_t;

  typedef struct packed {
    logic [7:0] name_byte;
    status_e    status;
    logic       last_result;
  } scan_result_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       s_axis_tvalid_i = 1'b0;
  logic       s_axis_tready_o;
  logic [7:0] s_axis_tdata_i = 8'h00;  // [7:0] data_byte
  logic       s_axis_tlast_i = 1'b0;   // end_of_region
  logic       m_axis_tvalid_o;
  logic       m_axis_tready_i = 1'b0;
  logic [7:0] m_axis_tdata_o;          // [7:0] name_byte
  logic [1:0] m_axis_tuser_o;          // [1:0] status
  logic       m_axis_tlast_o;          // last_result

  boot_name_prefix_scanner_core uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Bytes waiting to be sent and results waiting to be seen.
  region_byte_t region_bytes_q[$];
  scan_result_t scan_result_q[$];
  region_byte_t next_byte;
  int unsigned  total_bytes = 0;
  int unsigned  bytes_taken = 0;
  int unsigned  quiet_cycles = 0;
  int unsigned  err_count = 0;
  int unsigned  send_idle_pct;
  int unsigned  recv_idle_pct;
  logic         in_taken = 1'b0;

  // Scanner state as the predictor sees it.
  logic [7:0]  scan_win [NAME_BYTES];
  int unsigned scan_fill = 0;
  bit          scan_named = 1'b0;

  function automatic string prefix_text(int unsigned p);
    case (p)
      0: return "SCES_";
      1: return "SCED_";
      2: return "SLES";
      3: return "SLED_";
      4: return "SCPS_";
      5: return "SLPS_";
      6: return "SLPM_";
      7: return "SCUS_";
      8: return "SLUS_";
      9: return "PAPX_";
      default: return "PCPX_";
    endcase
  endfunction

  // A prefix counts only if it fits inside the bytes held so far.
  function automatic bit prefix_starts(int unsigned pos, int unsigned avail);
    string pfx;
    bit    same;
    for (int unsigned p = 0; p < 11; p++) begin
      pfx = prefix_text(p);
      if (pos + pfx.len() <= avail) begin
        same = 1'b1;
        for (int unsigned k = 0; k < pfx.len(); k++) begin
          if (scan_win[pos + k] != pfx[k]) same = 1'b0;
        end
        if (same) return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // Advance the predicted scanner by one accepted byte and queue its results.
  task automatic scan_byte(logic [7:0] b, logic last);
    bit           tail;
    scan_result_t res;
    if (!scan_named) begin
      if (scan_fill < NAME_BYTES) begin
        scan_win[scan_fill] = b;
        scan_fill++;
      end else begin
        for (int unsigned i = 0; i < NAME_BYTES - 1; i++) scan_win[i] = scan_win[i + 1];
        scan_win[NAME_BYTES - 1] = b;
      end
      if (scan_fill == NAME_BYTES && prefix_starts(0, NAME_BYTES)) begin
        for (int unsigned i = 0; i < NAME_BYTES; i++) begin
          res.name_byte   = scan_win[i];
          res.status      = ST_FOUND;
          res.last_result = (i == NAME_BYTES - 1);
          scan_result_q.push_back(res);
        end
        scan_named = 1'b1;
      end else if (last) begin
        // Position zero of a full window was just tested; check the rest.
        tail = 1'b0;
        for (int unsigned i = (scan_fill == NAME_BYTES) ? 1 : 0; i < scan_fill; i++) begin
          if (prefix_starts(i, scan_fill)) tail = 1'b1;
        end
        res.name_byte   = 8'h00;
        res.status      = tail ? ST_TRUNC : ST_NONE;
        res.last_result = 1'b1;
        scan_result_q.push_back(res);
      end
    end
    if (last) begin
      for (int unsigned i = 0; i < NAME_BYTES; i++) scan_win[i] = 8'h00;
      scan_fill  = 0;
      scan_named = 1'b0;
    end
  endtask

  task automatic push_byte(logic [7:0] b, logic last);
    region_byte_t item;
    item.data = b;
    item.last = last;
    region_bytes_q.push_back(item);
  endtask

  task automatic push_text(string s, logic last);
    for (int unsigned k = 0; k < s.len(); k++) push_byte(s[k], last && (k == s.len() - 1));
  endtask

  // One random region: mostly a planted prefix among near-miss letters, sometimes noise.
  task automatic push_random_region();
    logic [7:0]  region_buf [MAX_REGION];
    string       near_miss;
    string       pfx;
    int unsigned len;
    int unsigned pos;
    int unsigned plants;
    bit          noise;
    near_miss = "SCLEPUDMXA_";
    noise = ($urandom_range(9) == 0);
    len = ($urandom_range(3) == 0) ? $urandom_range(1, 12) : $urandom_range(8, MAX_REGION);
    for (int unsigned i = 0; i < len; i++) begin
      if (noise || $urandom_range(1) == 0) region_buf[i] = 8'($urandom_range(255));
      else region_buf[i] = near_miss[$urandom_range(near_miss.len() - 1)];
    end
    plants = noise ? 0 : $urandom_range(1, 2);
    for (int unsigned n = 0; n < plants; n++) begin
      pfx = prefix_text($urandom_range(10));
      pos = $urandom_range(len - 1);
      // Letters past the region end are dropped, leaving a cut-off prefix.
      for (int unsigned k = 0; k < pfx.len(); k++) begin
        if (pos + k < len) region_buf[pos + k] = pfx[k];
      end
    end
    for (int unsigned i = 0; i < len; i++) push_byte(region_buf[i], i == len - 1);
  endtask

  // Driver: present a new byte at the falling edge once the last one was taken.
  always @(negedge clk_i) begin
    if (bytes_taken < total_bytes / 3) begin
      send_idle_pct = 36;
      recv_idle_pct = 76;
    end else if (bytes_taken < 2 * total_bytes / 3) begin
      send_idle_pct = 76;
      recv_idle_pct = 36;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
    if (rst_ni && (!s_axis_tvalid_i || in_taken)) begin
      if (region_bytes_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        next_byte = region_bytes_q.pop_front();
        s_axis_tdata_i  <= next_byte.data;
        s_axis_tlast_i  <= next_byte.last;
        s_axis_tvalid_i <= 1'b1;
      end else begin
        s_axis_tvalid_i <= 1'b0;
      end
    end
    m_axis_tready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Monitor: predict on each input transaction, check each output transaction.
  always @(posedge clk_i) begin
    in_taken <= rst_ni && s_axis_tvalid_i && s_axis_tready_o;
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        scan_byte(s_axis_tdata_i, s_axis_tlast_i);
        bytes_taken++;
      end
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        if (scan_result_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual byte %02h status %0d last %0b",
                   $time, m_axis_tdata_o, m_axis_tuser_o, m_axis_tlast_o);
          err_count++;
        end else begin
          if (m_axis_tdata_o != scan_result_q[0].name_byte) begin
            $display("%0t: name_byte mismatch, expected %02h, actual %02h",
                     $time, scan_result_q[0].name_byte, m_axis_tdata_o);
            err_count++;
          end
          if (m_axis_tuser_o != scan_result_q[0].status) begin
            $display("%0t: status mismatch, expected %0d, actual %0d",
                     $time, scan_result_q[0].status, m_axis_tuser_o);
            err_count++;
          end
          if (m_axis_tlast_o != scan_result_q[0].last_result) begin
            $display("%0t: last_result mismatch, expected %0b, actual %0b",
                     $time, scan_result_q[0].last_result, m_axis_tlast_o);
            err_count++;
          end
          void'(scan_result_q.pop_front());
        end
      end
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("boot_name_prefix_scanner_core test failed");
        $finish;
      end
    end
  end

  initial begin
    for (int unsigned i = 0; i < NAME_BYTES; i++) scan_win[i] = 8'h00;

    // Four-byte prefix at the start, name completes on the region's last byte.
    push_text("SLES", 1'b0);
    push_byte(8'h00, 1'b0);
    push_text("-1234", 1'b0);
    push_byte(8'hFF, 1'b1);
    // Short region holding a whole prefix: truncated.
    push_text("PCPX_", 1'b1);
    // Single byte region: nothing found.
    push_byte(8'hFF, 1'b1);
    // Incomplete prefix at the region end: nothing found.
    push_text("SLE", 1'b1);
    // Four-byte prefix ending exactly at the region end: truncated.
    push_byte(8'h7F, 1'b0);
    push_text("SLES", 1'b1);

    while (region_bytes_q.size() < RANDOM_ITEMS + 25) push_random_region();
    total_bytes = region_bytes_q.size();

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Drain: every byte sent, every result seen, then a short settle.
    while (region_bytes_q.size() != 0 || s_axis_tvalid_i) @(negedge clk_i);
    while (scan_result_q.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    if (err_count == 0) begin
      $display("boot_name_prefix_scanner_core test passed");
    end else begin
      $display("boot_name_prefix_scanner_core test failed");
    end
    $finish;
  end

endmodule

[files.f]
design/bnps_pkg.sv
design/bnps_window.sv
design/bnps_emit.sv
design/boot_name_prefix_scanner_core.sv
tb/tb_top.sv
